### rtl/slt_pkg.sv
`default_nettype none

package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int ECNT_W   = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [ECNT_W-1:0] entry_count;
    logic              is_empty;
  } rsp_t;

  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] p);
    logic [IDX_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, p};
    return t[POS_W-1:0];
  endfunction

  function automatic logic [ECNT_W-1:0] to_ecnt(input logic [CNT_W-1:0] c);
    logic [CNT_W+ECNT_W-1:0] t;
    t = {{ECNT_W{1'b0}}, c};
    return t[ECNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/slt_ram.sv
`default_nettype none

module slt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/sorted_list_table.sv
// Sorted value table: signed 32-bit values held in ascending order in a
// single-port-read entry memory of CAPACITY words.
// Request channel (req_valid / req_stall / req): a beat carries a request
// type (insert, search, remove) and a value. Response channel
// (rsp_valid / rsp_stall / rsp): one beat per request with status,
// position, entry count and empty flag, in request order.
// One request is handled at a time. The memory is scanned one entry per
// cycle through its registered read port. Insert scans downward from the
// top, moving each value not smaller than the new one up one place;
// search scans from index 0 to the first match or the end; remove does
// as search, then moves the later entries down one place. The result is
// loaded into the response register; an empty or full table answers
// without a scan. req_stall is high while a request is in progress
// and while a finished response cannot be loaded because the previous
// one is still held by rsp_stall; a response held in the output register
// does not block the next request from being accepted.
// Reset clears the count and control state; the entry memory is not
// cleared, only entries below the count are ever read.
`default_nettype none

module sorted_list_table
  import slt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS      = 6'b000010,
    S_INS_LAST = 6'b000100,
    S_FIND     = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t            state, state_next;
  req_t              req_q, req_q_next;
  logic [IDX_W-1:0]  k, k_next;
  logic              dv, dv_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [1:0]        res_status, res_status_next;
  logic [IDX_W-1:0]  res_pos, res_pos_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [VAL_W-1:0]  wr_data, rd_data;

  logic [CNT_W-1:0]  kp1;
  logic              more;
  logic              accept;

  slt_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign kp1       = CNT_W'(k) + CNT_W'(1);
  assign more      = (kp1 < cnt);

  always_comb begin
    state_next      = state;
    req_q_next      = req_q;
    k_next          = k;
    dv_next         = dv;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    rd_en           = 1'b0;
    rd_addr         = k;
    wr_en           = 1'b0;
    wr_addr         = k;
    wr_data         = rd_data;

    case (state)
      S_IDLE: begin
        if (accept) begin
          req_q_next   = req;
          dv_next      = 1'b0;
          res_pos_next = '0;
          case (req.req_type)
            REQ_INSERT: begin
              if (cnt >= CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
                state_next      = S_RESULT;
              end else if (cnt == '0) begin
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data         = req.item_value;
                cnt_next        = cnt + CNT_W'(1);
                res_status_next = ST_OK;
                state_next      = S_RESULT;
              end else begin
                k_next     = IDX_W'(cnt - CNT_W'(1));
                state_next = S_INS;
              end
            end
            REQ_SEARCH, REQ_REMOVE: begin
              if (cnt == '0) begin
                res_status_next = ST_MISSING;
                state_next      = S_RESULT;
              end else begin
                k_next     = '0;
                state_next = S_FIND;
              end
            end
            default: begin
              res_status_next = ST_MISSING;
              state_next      = S_RESULT;
            end
          endcase
        end
      end

      S_INS: begin
        if (!dv) begin
          rd_en   = 1'b1;
          dv_next = 1'b1;
        end else if ($signed(rd_data) >= req_q.item_value) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(kp1);
          wr_data = rd_data;
          if (k == '0) begin
            state_next = S_INS_LAST;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k - IDX_W'(1);
            k_next  = k - IDX_W'(1);
          end
        end else begin
          wr_en           = 1'b1;
          wr_addr         = IDX_W'(kp1);
          wr_data         = req_q.item_value;
          res_pos_next    = IDX_W'(kp1);
          cnt_next        = cnt + CNT_W'(1);
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end

      S_INS_LAST: begin
        wr_en           = 1'b1;
        wr_addr         = '0;
        wr_data         = req_q.item_value;
        res_pos_next    = '0;
        cnt_next        = cnt + CNT_W'(1);
        res_status_next = ST_OK;
        state_next      = S_RESULT;
      end

      S_FIND: begin
        if (!dv) begin
          rd_en   = 1'b1;
          dv_next = 1'b1;
        end else if (rd_data == req_q.item_value) begin
          res_pos_next = k;
          if (req_q.req_type == REQ_SEARCH) begin
            res_status_next = ST_OK;
            state_next      = S_RESULT;
          end else if (more) begin
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(kp1);
            k_next     = IDX_W'(kp1);
            state_next = S_SHIFT;
          end else begin
            cnt_next        = cnt - CNT_W'(1);
            res_status_next = ST_OK;
            state_next      = S_RESULT;
          end
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(kp1);
          k_next  = IDX_W'(kp1);
        end else begin
          res_status_next = ST_MISSING;
          res_pos_next    = '0;
          state_next      = S_RESULT;
        end
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = k - IDX_W'(1);
        wr_data = rd_data;
        if (more) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(kp1);
          k_next  = IDX_W'(kp1);
        end else begin
          cnt_next        = cnt - CNT_W'(1);
          res_status_next = ST_OK;
          state_next      = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.status      = res_status;
          rsp_next.position    = to_pos(res_pos);
          rsp_next.entry_count = to_ecnt(cnt);
          rsp_next.is_empty    = (cnt == '0);
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dv        <= 1'b0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dv        <= dv_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    k          <= k_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    rsp        <= rsp_next;
  end

  // same-address read and write never overlap in a cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("entry memory read and write to the same address");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (cnt == $past(cnt)) || (cnt == $past(cnt) + CNT_W'(1)) ||
    (cnt + CNT_W'(1) == $past(cnt)))
    else $error("entry count moved by more than one");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request beat taken without entering a busy state");

  a_cnt_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (cnt != $past(cnt)) |-> (state == S_RESULT))
    else $error("entry count changed outside request completion");

endmodule

`default_nettype wire
